### rtl/core/pcd_pkg.sv
// Package with the shared types, codes and fixed-point helpers of the taper curve mapper.
`default_nettype none
package pcd_pkg;

  localparam int LOG_FRAC = 16;
  localparam int LW = 24;
  localparam int VW = 40;
  localparam int NW = 18;

  typedef enum logic [1:0] {
    MODE_LOG    = 2'd0,
    MODE_SQUARE = 2'd1,
    MODE_FOURTH = 2'd2,
    MODE_LINEAR = 2'd3
  } curve_mode_t;

  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_MIN   = 2'd1,
    REG_MAX   = 2'd2,
    REG_ROUND = 2'd3
  } reg_index_t;

  typedef struct packed {
    curve_mode_t        mode;
    logic signed [31:0] rmin;
    logic signed [31:0] rmax;
    logic               rnd;
  } cfg_t;

  typedef struct packed {
    logic                 valid;
    logic signed [LW-1:0] lval;
    logic signed [VW-1:0] vlin;
  } front_out_t;

  function automatic logic signed [63:0] shr_rnd(input logic signed [63:0] x,
                                                 input int unsigned s);
    logic       neg;
    logic [63:0] a;
    neg = x[63];
    a = neg ? 64'(-x) : 64'(x);
    a = (a + (64'd1 << (s - 1))) >> s;
    return neg ? -$signed(a) : $signed(a);
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] xv;
    r = 64'd0;
    b = 64'd1 << 62;
    xv = x;
    for (int i = 0; i < 32; i++) begin
      if (xv >= r + b) begin
        xv = xv - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] exp_factor(input int j);
    logic [63:0] c;
    c = isqrt64(64'd2 << 60);
    for (int i = 0; i < 16; i++) begin
      if (i < j) begin
        c = isqrt64(c << 30);
      end
    end
    return c[31:0];
  endfunction

endpackage
`default_nettype wire

### rtl/core/pcd_log_unit.sv
// Iterative base-two logarithm of the range limits, recomputed after reset and limit writes.
`default_nettype none
module pcd_log_unit
  import pcd_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 restart,
  input  wire logic signed [31:0]   rmin,
  input  wire logic signed [31:0]   rmax,
  output logic                      busy,
  output logic signed [LW-1:0]      lmin,
  output logic signed [LW-1:0]      lmax
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_NORM = 3'b010,
    ST_SQ   = 3'b100
  } state_t;

  state_t      state;
  logic        sel;
  logic [3:0]  cnt;
  logic [31:0] m;
  logic [15:0] frac;
  logic [4:0]  pos;

  logic [31:0]        x;
  logic [4:0]         lead;
  logic [63:0]        sq;
  logic [32:0]        m2;
  logic [15:0]        frac_next;
  logic signed [7:0]  pexp;
  logic signed [LW-1:0] res;

  always_comb begin
    x = sel ? rmax : rmin;
    lead = 5'd0;
    for (int i = 0; i < 31; i++) begin
      if (x[i]) begin
        lead = 5'(i);
      end
    end
    sq = m * m;
    m2 = sq[63:31];
    frac_next = frac;
    if (m2[32]) begin
      frac_next[cnt] = 1'b1;
    end
    pexp = $signed({3'b000, pos}) - 8'(FRAC_BITS);
    res = {pexp, frac_next};
  end

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_NORM;
      sel <= 1'b0;
      cnt <= 4'd0;
    end else if (restart) begin
      state <= ST_NORM;
      sel <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          state <= ST_IDLE;
        end
        ST_NORM: begin
          pos <= lead;
          m <= {1'b0, x[30:0]} << (5'd31 - lead);
          frac <= 16'd0;
          cnt <= 4'd15;
          state <= ST_SQ;
        end
        ST_SQ: begin
          m <= m2[32] ? m2[32:1] : m2[31:0];
          frac <= frac_next;
          cnt <= cnt - 4'd1;
          if (cnt == 4'd0) begin
            if (sel) begin
              lmax <= res;
              state <= ST_IDLE;
            end else begin
              lmin <= res;
              sel <= 1'b1;
              state <= ST_NORM;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/core/pcd_front.sv
// Front pipeline: clamp, powers of the position, log interpolation and the polynomial tapers.
`default_nettype none
module pcd_front
  import pcd_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic signed [17:0]   norm_in,
  input  wire cfg_t                 cfg,
  input  wire logic signed [LW-1:0] lmin,
  input  wire logic signed [LW-1:0] lmax,
  output front_out_t                fo
);

  localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;
  localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);

  logic [4:0] vld;

  logic [NW-1:0] n0, n1, n2s, n2, n3, n4s;
  logic signed [43:0]   lp1;
  logic signed [LW-1:0] l2, l3, l4;
  logic signed [51:0]   prod3;
  logic signed [VW-1:0] vlin4;

  logic [NW-1:0]        n_clamp;
  logic [35:0]          sq_a;
  logic [35:0]          sq_b;
  logic signed [LW:0]   ldiff;
  logic signed [32:0]   diff;
  logic [NW-1:0]        shape;
  logic signed [63:0]   lsum;
  logic signed [63:0]   vsum;

  always_comb begin
    if (norm_in[17]) begin
      n_clamp = '0;
    end else if ({14'd0, norm_in} > ONE) begin
      n_clamp = ONE[NW-1:0];
    end else begin
      n_clamp = norm_in[NW-1:0];
    end
    sq_a = n0 * n0;
    sq_b = n2s * n2s;
    ldiff = (LW+1)'(lmax) - (LW+1)'(lmin);
    diff = 33'(cfg.rmax) - 33'(cfg.rmin);
    case (cfg.mode)
      MODE_SQUARE: shape = n2;
      MODE_FOURTH: shape = n4s;
      default:     shape = n3;
    endcase
    lsum = 64'(lmin) + shr_rnd(64'(lp1), FRAC_BITS);
    vsum = 64'(cfg.rmin) + shr_rnd(64'(prod3), FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], in_valid};
    end
    n0 <= n_clamp;
    n1 <= n0;
    n2s <= NW'((64'(sq_a) + HALF) >> FRAC_BITS);
    lp1 <= ldiff * $signed({1'b0, n0});
    n2 <= n2s;
    n3 <= n1;
    n4s <= NW'((64'(sq_b) + HALF) >> FRAC_BITS);
    l2 <= LW'(lsum);
    prod3 <= diff * $signed({1'b0, shape});
    l3 <= l2;
    vlin4 <= VW'(vsum);
    l4 <= l3;
  end

  assign fo.valid = vld[4];
  assign fo.lval = l4;
  assign fo.vlin = vlin4;

endmodule
`default_nettype wire

### rtl/core/pcd_exp2.sv
// Pipelined base-two exponential: sixteen rounded factor stages and a saturating scale stage.
`default_nettype none
module pcd_exp2
  import pcd_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic signed [LW-1:0] lval,
  output logic                      out_valid,
  output logic [31:0]               vlog
);

  localparam logic [63:0] SAT = 64'h0000_0000_7FFF_FFFF;

  logic [31:0]       r_q  [17];
  logic [15:0]       f_q  [17];
  logic signed [7:0] ip_q [17];
  logic [16:0]       v_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= in_valid;
    end
    r_q[0] <= 32'd1 << 30;
    f_q[0] <= lval[15:0];
    ip_q[0] <= lval[LW-1:16];
  end

  for (genvar j = 0; j < 16; j++) begin : g_stage
    localparam logic [31:0] C = exp_factor(j);
    logic [63:0] pr;
    assign pr = r_q[j] * C;
    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[j+1] <= 1'b0;
      end else begin
        v_q[j+1] <= v_q[j];
      end
      r_q[j+1] <= f_q[j][15-j] ? 32'((pr + (64'd1 << 29)) >> 30) : r_q[j];
      f_q[j+1] <= f_q[j];
      ip_q[j+1] <= ip_q[j];
    end
  end

  logic signed [9:0] sh;
  logic [9:0]        ns;
  logic [63:0]       wide;
  logic [31:0]       scaled;

  always_comb begin
    sh = 10'(ip_q[16]) + 10'(FRAC_BITS) - 10'sd30;
    ns = 10'(-sh);
    wide = '0;
    if (!sh[9]) begin
      wide = 64'(r_q[16]) << sh[5:0];
      if (sh > 10'sd32 || wide > SAT) begin
        scaled = SAT[31:0];
      end else begin
        scaled = wide[31:0];
      end
    end else if (ns >= 10'd62) begin
      scaled = 32'd0;
    end else begin
      wide = (64'(r_q[16]) + (64'd1 << (ns[5:0] - 6'd1))) >> ns[5:0];
      scaled = wide[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v_q[16];
    end
    vlog <= scaled;
  end

endmodule
`default_nettype wire

### rtl/core/pcd_back.sv
// Back pipeline: curve selection, optional rounding to whole numbers and the final range clamp.
`default_nettype none
module pcd_back
  import pcd_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cfg_t                 cfg,
  input  wire logic                 in_valid,
  input  wire logic [31:0]          vlog,
  input  wire logic signed [VW-1:0] vlin,
  output logic                      done,
  output logic signed [31:0]        value_out
);

  logic                 v1;
  logic signed [VW-1:0] val1;
  logic                 bad;
  logic signed [VW-1:0] sel;
  logic signed [63:0]   rnd;
  logic signed [VW-1:0] clamped;

  always_comb begin
    bad = (cfg.rmin <= 32'sd0) || (cfg.rmax <= 32'sd0);
    if (cfg.mode == MODE_LOG) begin
      sel = bad ? VW'(cfg.rmin) : VW'({1'b0, vlog});
    end else begin
      sel = vlin;
    end
    rnd = shr_rnd(64'(sel), FRAC_BITS) <<< FRAC_BITS;
    clamped = val1;
    if (clamped < VW'(cfg.rmin)) begin
      clamped = VW'(cfg.rmin);
    end
    if (clamped > VW'(cfg.rmax)) begin
      clamped = VW'(cfg.rmax);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= in_valid;
      done <= v1;
    end
    val1 <= cfg.rnd ? VW'(rnd) : sel;
    value_out <= clamped[31:0];
  end

endmodule
`default_nettype wire

### rtl/core/param_curve_denormalize_core.sv
// Top level of the taper curve mapper: configuration registers and the result pipeline.
//
// Maps a normalised Q2.16 position to a parameter value along a logarithmic, squared,
// fourth-power or linear taper between range_min and range_max. A request is taken on
// any cycle where start is high and busy is low, one per cycle, and its result appears
// with done once it leaves the back pipeline; the receiver cannot stall, so results are never
// held. The depth is set by the sixteen rounded multiply stages of the exponential. After
// reset and after each write of range_min or range_max, busy stays high while the
// logarithms of the limits are formed by repeated squaring.
`default_nettype none
module param_curve_denormalize_core
  import pcd_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [17:0] norm_in,
  output logic                    done,
  output logic signed [31:0]      value_out,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  cfg_t                 cfg;
  logic                 wr_en;
  reg_index_t           widx;
  logic                 restart;
  logic signed [LW-1:0] lmin, lmax;
  front_out_t           fo;
  logic                 e_valid;
  logic [31:0]          vlog;
  logic signed [VW-1:0] dl [18];

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;
  assign widx = reg_index_t'(paddr[3:2]);
  assign restart = wr_en && (widx == REG_MIN || widx == REG_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode <= MODE_LINEAR;
      cfg.rmin <= 32'sd0;
      cfg.rmax <= 32'sd65536;
      cfg.rnd <= 1'b0;
    end else if (wr_en) begin
      case (widx)
        REG_MODE:  cfg.mode <= curve_mode_t'(pwdata[1:0]);
        REG_MIN:   cfg.rmin <= pwdata;
        REG_MAX:   cfg.rmax <= pwdata;
        REG_ROUND: cfg.rnd <= pwdata[0];
        default:   cfg.rnd <= cfg.rnd;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_MODE:  prdata = {30'd0, cfg.mode};
      REG_MIN:   prdata = cfg.rmin;
      REG_MAX:   prdata = cfg.rmax;
      REG_ROUND: prdata = {31'd0, cfg.rnd};
      default:   prdata = '0;
    endcase
  end

  pcd_log_unit #(.FRAC_BITS(FRAC_BITS)) u_log (
    .clk(clk), .rst(rst), .restart(restart), .rmin(cfg.rmin), .rmax(cfg.rmax),
    .busy(busy), .lmin(lmin), .lmax(lmax)
  );

  pcd_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .in_valid(start && !busy), .norm_in(norm_in), .cfg(cfg),
    .lmin(lmin), .lmax(lmax), .fo(fo)
  );

  pcd_exp2 #(.FRAC_BITS(FRAC_BITS)) u_exp (
    .clk(clk), .rst(rst), .in_valid(fo.valid), .lval(fo.lval),
    .out_valid(e_valid), .vlog(vlog)
  );

  always_ff @(posedge clk) begin
    dl[0] <= fo.vlin;
    for (int i = 1; i < 18; i++) begin
      dl[i] <= dl[i-1];
    end
  end

  pcd_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .in_valid(e_valid), .vlog(vlog), .vlin(dl[17]),
    .done(done), .value_out(value_out)
  );

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##25 done)
    else $error("Request did not complete after the pipeline depth.");

  a_in_range: assert property (@(posedge clk) disable iff (rst)
    (done && cfg.rmin <= cfg.rmax) |-> (value_out >= cfg.rmin && value_out <= cfg.rmax))
    else $error("Result lies outside the configured range.");
`endif

endmodule
`default_nettype wire
